/* src/sip_pkg.sv */
package sip_pkg;

    localparam int EPS_W = 20;

    localparam logic KIND_BOUNDED  = 1'b0;
    localparam logic KIND_EXTENDED = 1'b1;

    typedef struct packed {
        logic valid;
        logic hit;
        logic fb;
        logic neg_x;
        logic neg_y;
    } t_ctl;

endpackage

/* src/sip_cell.sv */
module sip_cell #(
    parameter int DEN_W  = 35,
    parameter int ACC_W  = 62,
    parameter int PASS_W = 36
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sip_pkg::t_ctl       i_ctl,
    input  logic [DEN_W-1:0]    i_den,
    input  logic [DEN_W-1:0]    i_rem_x,
    input  logic [ACC_W-1:0]    i_acc_x,
    input  logic [DEN_W-1:0]    i_rem_y,
    input  logic [ACC_W-1:0]    i_acc_y,
    input  logic [PASS_W-1:0]   i_pass,
    output sip_pkg::t_ctl       o_ctl,
    output logic [DEN_W-1:0]    o_den,
    output logic [DEN_W-1:0]    o_rem_x,
    output logic [ACC_W-1:0]    o_acc_x,
    output logic [DEN_W-1:0]    o_rem_y,
    output logic [ACC_W-1:0]    o_acc_y,
    output logic [PASS_W-1:0]   o_pass
);
    import sip_pkg::*;

    logic [DEN_W:0]   n_tx;
    logic [DEN_W:0]   n_ty;
    logic             n_gex;
    logic             n_gey;
    t_ctl             r_ctl;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem_x;
    logic [DEN_W-1:0] r_rem_y;
    logic [ACC_W-1:0] r_acc_x;
    logic [ACC_W-1:0] r_acc_y;
    logic [PASS_W-1:0] r_pass;

    // one restoring division step: top dividend bit into the remainder
    always_comb begin
        n_tx  = {i_rem_x, i_acc_x[ACC_W-1]};
        n_ty  = {i_rem_y, i_acc_y[ACC_W-1]};
        n_gex = n_tx >= {1'b0, i_den};
        n_gey = n_ty >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den   <= i_den;
        r_rem_x <= n_gex ? DEN_W'(n_tx - {1'b0, i_den}) : DEN_W'(n_tx);
        r_rem_y <= n_gey ? DEN_W'(n_ty - {1'b0, i_den}) : DEN_W'(n_ty);
        r_acc_x <= {i_acc_x[ACC_W-2:0], n_gex};
        r_acc_y <= {i_acc_y[ACC_W-2:0], n_gey};
        r_pass  <= i_pass;
    end

    assign o_ctl   = r_ctl;
    assign o_den   = r_den;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;
    assign o_pass  = r_pass;

endmodule

/* src/segment_intersection_point_core.sv */
// Intersection point of two 2-D segments A and B.
// Request: raise i_start with the kind bit and the eight endpoint coordinates;
// o_busy stays low, so a request is taken in every cycle, one pair per cycle.
// Kind bounded runs the two side tests, a near-parallel hit giving the mean
// of the four endpoints; kind extended treats both as lines and drops
// near-parallel pairs. Points are signed fixed point with FRAC_BITS fraction
// bits, rounded to nearest and saturated. The result is on the o_ ports for
// one cycle, marked by o_strobe. The pipeline is a division chain: one cell
// per quotient bit, 3*COORD_BITS+FRAC_BITS+6 cells, behind five front stages
// for products and sums and one output stage for clamping.
// The receiver cannot stall; results leave in request order.
// i_cfg_we with i_cfg_data writes the parallel epsilon; the user writes it
// only while idle, unchecked by the block. Reset (synchronous, low) empties
// the pipeline and clears the epsilon to 0; requests in flight are dropped.
module segment_intersection_point_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_cfg_we,
    input  logic [sip_pkg::EPS_W-1:0]             i_cfg_data,
    input  logic                                  i_kind,
    input  logic signed [COORD_BITS-1:0]          i_a_start_x,
    input  logic signed [COORD_BITS-1:0]          i_a_start_y,
    input  logic signed [COORD_BITS-1:0]          i_a_end_x,
    input  logic signed [COORD_BITS-1:0]          i_a_end_y,
    input  logic signed [COORD_BITS-1:0]          i_b_start_x,
    input  logic signed [COORD_BITS-1:0]          i_b_start_y,
    input  logic signed [COORD_BITS-1:0]          i_b_end_x,
    input  logic signed [COORD_BITS-1:0]          i_b_end_y,
    output logic                                  o_strobe,
    output logic                                  o_hit,
    output logic                                  o_parallel_fallback,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_point_y,
    output logic                                  o_saturated
);
    import sip_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int SW = CW + 2;
    localparam int PW = 2 * DW;
    localparam int XW = 2 * CW + 3;
    localparam int NW = 3 * CW + 5;
    localparam int W  = NW + FRAC_BITS + 1;
    localparam int PT = CW + FRAC_BITS;

    logic [EPS_W-1:0] r_eps;

    // stage 1: differences and endpoint sums
    logic                 r1_v;
    logic                 r1_kind;
    logic signed [CW-1:0] r1_ax, r1_ay;
    logic signed [DW-1:0] r1_dax, r1_day, r1_dbx, r1_dby;
    logic signed [DW-1:0] r1_cax, r1_cay, r1_eax, r1_eay;
    logic signed [DW-1:0] r1_acx, r1_acy, r1_bcx, r1_bcy;
    logic signed [SW-1:0] r1_sx, r1_sy;

    // stage 2: products
    logic                 r2_v;
    logic                 r2_kind;
    logic signed [CW-1:0] r2_ax, r2_ay;
    logic signed [DW-1:0] r2_dax, r2_day;
    logic signed [SW-1:0] r2_sx, r2_sy;
    logic signed [PW-1:0] r2_pd0, r2_pd1, r2_pn0, r2_pn1;
    logic signed [PW-1:0] r2_p10, r2_p11, r2_p20, r2_p21;
    logic signed [PW-1:0] r2_p30, r2_p31, r2_p40, r2_p41;

    // stage 3: cross products, side tests, sign normalization
    logic signed [XW-1:0] n_den, n_num, n_c1, n_c2, n_c3, n_c4;
    logic [XW-1:0]        n_mag;
    logic                 n_s1, n_s2, n_s3, n_s4, n_par, n_hit;
    t_ctl                 r3_ctl;
    logic [XW-1:0]        r3_den;
    logic signed [XW-1:0] r3_num;
    logic signed [CW-1:0] r3_ax, r3_ay;
    logic signed [DW-1:0] r3_dax, r3_day;
    logic signed [SW-1:0] r3_sx, r3_sy;

    // stage 4: numerator products
    t_ctl                 r4_ctl;
    logic [XW-1:0]        r4_den;
    logic signed [NW-1:0] r4_ma_x, r4_md_x, r4_ma_y, r4_md_y;
    logic signed [SW-1:0] r4_sx, r4_sy;

    // stage 5: dividend magnitude with rounding half
    logic signed [NW-1:0] n_nx, n_ny;
    logic [NW-1:0]        n_mx, n_my;
    t_ctl                 n5_ctl;
    t_ctl                 r5_ctl;
    logic [XW-1:0]        r5_den;
    logic [W-1:0]         r5_acc_x, r5_acc_y;
    logic signed [SW-1:0] r5_sx, r5_sy;

    // division chain taps
    t_ctl                w_ctl   [0:W];
    logic [XW-1:0]       w_den   [0:W];
    logic [XW-1:0]       w_rem_x [0:W];
    logic [XW-1:0]       w_rem_y [0:W];
    logic [W-1:0]        w_acc_x [0:W];
    logic [W-1:0]        w_acc_y [0:W];
    logic [2*SW-1:0]     w_pass  [0:W];

    // output stage
    logic [W-1:0]         n_lim_x, n_lim_y, n_qx, n_qy;
    logic                 n_sat_x, n_sat_y;
    logic [PT-1:0]        n_vx, n_vy, n_fx, n_fy;
    logic [PT-1:0]        n_px, n_py;
    logic                 n_sat;
    logic                 r_strobe, r_hit, r_fb, r_sat;
    logic [PT-1:0]        r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps    <= '0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_ctl   <= '0;
            r4_ctl   <= '0;
            r5_ctl   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_data;
            end
            r1_v     <= i_start;
            r2_v     <= r1_v;
            r3_ctl   <= '{valid: r2_v, hit: n_hit,
                          fb: n_hit && n_par && (r2_kind == KIND_BOUNDED),
                          neg_x: 1'b0, neg_y: 1'b0};
            r4_ctl   <= r3_ctl;
            r5_ctl   <= n5_ctl;
            r_strobe <= w_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_kind <= i_kind;
        r1_ax   <= i_a_start_x;
        r1_ay   <= i_a_start_y;
        r1_dax  <= DW'(i_a_end_x) - DW'(i_a_start_x);
        r1_day  <= DW'(i_a_end_y) - DW'(i_a_start_y);
        r1_dbx  <= DW'(i_b_end_x) - DW'(i_b_start_x);
        r1_dby  <= DW'(i_b_end_y) - DW'(i_b_start_y);
        r1_cax  <= DW'(i_b_start_x) - DW'(i_a_start_x);
        r1_cay  <= DW'(i_b_start_y) - DW'(i_a_start_y);
        r1_eax  <= DW'(i_b_end_x) - DW'(i_a_start_x);
        r1_eay  <= DW'(i_b_end_y) - DW'(i_a_start_y);
        r1_acx  <= DW'(i_a_start_x) - DW'(i_b_start_x);
        r1_acy  <= DW'(i_a_start_y) - DW'(i_b_start_y);
        r1_bcx  <= DW'(i_a_end_x) - DW'(i_b_start_x);
        r1_bcy  <= DW'(i_a_end_y) - DW'(i_b_start_y);
        r1_sx   <= SW'(i_a_start_x) + SW'(i_a_end_x) + SW'(i_b_start_x) + SW'(i_b_end_x);
        r1_sy   <= SW'(i_a_start_y) + SW'(i_a_end_y) + SW'(i_b_start_y) + SW'(i_b_end_y);
    end

    always_ff @(posedge i_clk) begin
        r2_kind <= r1_kind;
        r2_ax   <= r1_ax;
        r2_ay   <= r1_ay;
        r2_dax  <= r1_dax;
        r2_day  <= r1_day;
        r2_sx   <= r1_sx;
        r2_sy   <= r1_sy;
        r2_pd0  <= PW'(r1_dax) * PW'(r1_dby);
        r2_pd1  <= PW'(r1_day) * PW'(r1_dbx);
        r2_pn0  <= PW'(r1_cax) * PW'(r1_dby);
        r2_pn1  <= PW'(r1_cay) * PW'(r1_dbx);
        r2_p10  <= PW'(r1_dax) * PW'(r1_cay);
        r2_p11  <= PW'(r1_day) * PW'(r1_cax);
        r2_p20  <= PW'(r1_dax) * PW'(r1_eay);
        r2_p21  <= PW'(r1_day) * PW'(r1_eax);
        r2_p30  <= PW'(r1_dbx) * PW'(r1_acy);
        r2_p31  <= PW'(r1_dby) * PW'(r1_acx);
        r2_p40  <= PW'(r1_dbx) * PW'(r1_bcy);
        r2_p41  <= PW'(r1_dby) * PW'(r1_bcx);
    end

    always_comb begin
        n_den = XW'(r2_pd0) - XW'(r2_pd1);
        n_num = XW'(r2_pn0) - XW'(r2_pn1);
        n_c1  = XW'(r2_p10) - XW'(r2_p11);
        n_c2  = XW'(r2_p20) - XW'(r2_p21);
        n_c3  = XW'(r2_p30) - XW'(r2_p31);
        n_c4  = XW'(r2_p40) - XW'(r2_p41);
        // zero counts on the negative side
        n_s1  = !n_c1[XW-1] && (n_c1 != '0);
        n_s2  = !n_c2[XW-1] && (n_c2 != '0);
        n_s3  = !n_c3[XW-1] && (n_c3 != '0);
        n_s4  = !n_c4[XW-1] && (n_c4 != '0);
        n_mag = n_den[XW-1] ? XW'(-n_den) : XW'(n_den);
        n_par = {{EPS_W{1'b0}}, n_mag} <= {{XW{1'b0}}, r_eps};
        if (r2_kind == KIND_BOUNDED) begin
            n_hit = !((n_s1 == n_s2) || (n_s3 == n_s4));
        end else begin
            n_hit = !n_par;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_den <= n_mag;
        r3_num <= n_den[XW-1] ? XW'(-n_num) : n_num;
        r3_ax  <= r2_ax;
        r3_ay  <= r2_ay;
        r3_dax <= r2_dax;
        r3_day <= r2_day;
        r3_sx  <= r2_sx;
        r3_sy  <= r2_sy;
    end

    always_ff @(posedge i_clk) begin
        r4_den  <= r3_den;
        r4_sx   <= r3_sx;
        r4_sy   <= r3_sy;
        r4_ma_x <= NW'(r3_ax) * NW'($signed({1'b0, r3_den}));
        r4_ma_y <= NW'(r3_ay) * NW'($signed({1'b0, r3_den}));
        r4_md_x <= NW'(r3_dax) * NW'(r3_num);
        r4_md_y <= NW'(r3_day) * NW'(r3_num);
    end

    always_comb begin
        n_nx   = r4_ma_x + r4_md_x;
        n_ny   = r4_ma_y + r4_md_y;
        n_mx   = n_nx[NW-1] ? NW'(-n_nx) : NW'(n_nx);
        n_my   = n_ny[NW-1] ? NW'(-n_ny) : NW'(n_ny);
        n5_ctl = r4_ctl;
        n5_ctl.neg_x = n_nx[NW-1];
        n5_ctl.neg_y = n_ny[NW-1];
    end

    always_ff @(posedge i_clk) begin
        r5_den   <= r4_den;
        r5_sx    <= r4_sx;
        r5_sy    <= r4_sy;
        r5_acc_x <= (W'(n_mx) << FRAC_BITS) + W'(r4_den >> 1);
        r5_acc_y <= (W'(n_my) << FRAC_BITS) + W'(r4_den >> 1);
    end

    assign w_ctl[0]   = r5_ctl;
    assign w_den[0]   = r5_den;
    assign w_rem_x[0] = '0;
    assign w_rem_y[0] = '0;
    assign w_acc_x[0] = r5_acc_x;
    assign w_acc_y[0] = r5_acc_y;
    assign w_pass[0]  = {r5_sx, r5_sy};

    for (genvar k = 0; k < W; k++) begin : g_cell
        sip_cell #(
            .DEN_W  (XW),
            .ACC_W  (W),
            .PASS_W (2 * SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .i_den   (w_den[k]),
            .i_rem_x (w_rem_x[k]),
            .i_acc_x (w_acc_x[k]),
            .i_rem_y (w_rem_y[k]),
            .i_acc_y (w_acc_y[k]),
            .i_pass  (w_pass[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_den   (w_den[k+1]),
            .o_rem_x (w_rem_x[k+1]),
            .o_acc_x (w_acc_x[k+1]),
            .o_rem_y (w_rem_y[k+1]),
            .o_acc_y (w_acc_y[k+1]),
            .o_pass  (w_pass[k+1])
        );
    end

    always_comb begin
        // negative side may reach one step further
        n_lim_x = (W'(1) << (PT - 1)) - (w_ctl[W].neg_x ? W'(0) : W'(1));
        n_lim_y = (W'(1) << (PT - 1)) - (w_ctl[W].neg_y ? W'(0) : W'(1));
        n_sat_x = w_acc_x[W] > n_lim_x;
        n_sat_y = w_acc_y[W] > n_lim_y;
        n_qx    = n_sat_x ? n_lim_x : w_acc_x[W];
        n_qy    = n_sat_y ? n_lim_y : w_acc_y[W];
        n_vx    = w_ctl[W].neg_x ? PT'(-n_qx) : PT'(n_qx);
        n_vy    = w_ctl[W].neg_y ? PT'(-n_qy) : PT'(n_qy);
        // mean of four endpoints never leaves the output range
        n_fx    = PT'($signed(w_pass[W][2*SW-1:SW])) << (FRAC_BITS - 2);
        n_fy    = PT'($signed(w_pass[W][SW-1:0])) << (FRAC_BITS - 2);
        if (!w_ctl[W].hit) begin
            n_px  = '0;
            n_py  = '0;
            n_sat = 1'b0;
        end else if (w_ctl[W].fb) begin
            n_px  = n_fx;
            n_py  = n_fy;
            n_sat = 1'b0;
        end else begin
            n_px  = n_vx;
            n_py  = n_vy;
            n_sat = n_sat_x || n_sat_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= w_ctl[W].hit;
        r_fb  <= w_ctl[W].fb;
        r_px  <= n_px;
        r_py  <= n_py;
        r_sat <= n_sat;
    end

    assign o_busy              = 1'b0;
    assign o_strobe            = r_strobe;
    assign o_hit               = r_hit;
    assign o_parallel_fallback = r_fb;
    assign o_point_x           = r_px;
    assign o_point_y           = r_py;
    assign o_saturated         = r_sat;

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (!o_parallel_fallback && !o_saturated
            && o_point_x == '0 && o_point_y == '0))
        else $error("miss result carries nonzero fields");

    a_fb_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_parallel_fallback) |-> (o_hit && !o_saturated))
        else $error("fallback result without hit or with saturation");

    a_chain_fb : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[0].valid && w_ctl[0].fb) |-> w_ctl[0].hit)
        else $error("fallback flag entered chain without hit");

endmodule
